### sv/dox_pkg.sv
// types and constants shared by the option extractor modules
// no dependencies
package dox_pkg;

  localparam logic [7:0] OPT_END = 8'd255;

  localparam logic [1:0] REG_WANTED_TYPE = 2'd0;
  localparam logic [1:0] REG_COPY_LENGTH = 2'd1;
  localparam logic [1:0] REG_EXACT_MODE  = 2'd2;

  localparam logic [7:0] WANTED_TYPE_RST = 8'd53;
  localparam logic [7:0] COPY_LENGTH_RST = 8'd1;

  localparam logic RK_BYTE   = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN,
    PH_LEN_HIT,
    PH_SKIP,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       area_last;
  } in_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] copied_byte;
    logic       found;
    logic [7:0] byte_count;
    logic       run_last;
  } out_t;

  typedef struct packed {
    logic [7:0] wanted_type;
    logic [7:0] copy_length;
    logic       exact_mode;
  } cfg_t;

  // one step's worth of results, as queued between front and back
  typedef struct packed {
    logic       has_byte;
    logic [7:0] copied_byte;
    logic       has_status;
    logic       found;
    logic [7:0] byte_count;
  } act_t;

endpackage

### sv/dox_front.sv
// front end: accepts option bytes and walks the tlv records
// depends on dox_pkg
module dox_front import dox_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic q_full,
  output logic q_push,
  output act_t q_data
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] body_left_r, body_left_nxt;
  logic [7:0] copy_left_r, copy_left_nxt;
  logic [7:0] emitted_r, emitted_nxt;
  logic       verdict_r, verdict_nxt;

  logic       accept;
  logic [7:0] b;
  logic       emit;
  logic [7:0] bl_dec;
  logic [7:0] cl_dec;
  logic [7:0] min_len;
  logic       run_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.option_byte;
  assign bl_dec   = (body_left_r != 8'd0) ? 8'(body_left_r - 8'd1) : body_left_r;
  assign cl_dec   = 8'(copy_left_r - 8'd1);
  assign min_len  = (b < cfg.copy_length) ? b : cfg.copy_length;

  always_comb begin
    phase_nxt     = phase_r;
    body_left_nxt = body_left_r;
    copy_left_nxt = copy_left_r;
    emitted_nxt   = emitted_r;
    verdict_nxt   = verdict_r;
    emit          = 1'b0;
    unique case (phase_r)
      PH_TYPE: begin
        if (b == OPT_END) phase_nxt = PH_DONE;
        else if (b == cfg.wanted_type) phase_nxt = PH_LEN_HIT;
        else phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        body_left_nxt = b;
        phase_nxt     = (b != 8'd0) ? PH_SKIP : PH_TYPE;
      end
      PH_SKIP: begin
        body_left_nxt = bl_dec;
        if (bl_dec == 8'd0) phase_nxt = PH_TYPE;
      end
      PH_LEN_HIT: begin
        body_left_nxt = b;
        if (cfg.exact_mode) begin
          if (b < cfg.copy_length) begin
            verdict_nxt = 1'b0;
            phase_nxt   = PH_DONE;
          end else if (b == 8'd0) begin
            verdict_nxt = 1'b1;
            phase_nxt   = PH_DONE;
          end else begin
            copy_left_nxt = cfg.copy_length;
            phase_nxt     = PH_BODY;
          end
        end else begin
          verdict_nxt   = 1'b1;
          copy_left_nxt = min_len;
          phase_nxt     = (min_len != 8'd0) ? PH_BODY : PH_DONE;
        end
      end
      PH_BODY: begin
        if (copy_left_r != 8'd0) begin
          emit          = 1'b1;
          copy_left_nxt = cl_dec;
          emitted_nxt   = 8'(emitted_r + 8'd1);
        end
        body_left_nxt = bl_dec;
        if (cfg.exact_mode) begin
          if (bl_dec == 8'd0) begin
            verdict_nxt = 1'b1;
            phase_nxt   = PH_DONE;
          end
        end else if (copy_left_nxt == 8'd0) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: phase_nxt = PH_DONE;
      default: phase_nxt = PH_DONE;
    endcase
  end

  assign run_end = in_data.area_last;

  always_comb begin
    q_data.has_byte    = emit;
    q_data.copied_byte = b;
    q_data.has_status  = run_end;
    q_data.found       = verdict_nxt;
    q_data.byte_count  = emitted_nxt;
  end

  assign q_push = accept && (emit || run_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      body_left_r <= 8'd0;
      copy_left_r <= 8'd0;
      emitted_r   <= 8'd0;
      verdict_r   <= 1'b0;
    end else if (accept) begin
      if (run_end) begin
        phase_r     <= PH_TYPE;
        body_left_r <= 8'd0;
        copy_left_r <= 8'd0;
        emitted_r   <= 8'd0;
        verdict_r   <= 1'b0;
      end else begin
        phase_r     <= phase_nxt;
        body_left_r <= body_left_nxt;
        copy_left_r <= copy_left_nxt;
        emitted_r   <= emitted_nxt;
        verdict_r   <= verdict_nxt;
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY && copy_left_r != 8'd0 && in_valid && in_ready) |=>
      emitted_r == 8'($past(emitted_r) + 8'd1) || $past(in_data.area_last))
    else $error("emitted count did not advance on a copied byte");

endmodule

### sv/dox_queue.sv
// short fifo of step results between front and back
// depends on dox_pkg
module dox_queue import dox_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  act_t push_data,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output act_t q_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  act_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PW'(wr_ptr_r + 1'b1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PW'(rd_ptr_r + 1'b1);
    if (push && !pop) count_nxt = CW'(count_r + 1'b1);
    else if (pop && !push) count_nxt = CW'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count out of range");

endmodule

### sv/dox_back.sv
// back end: turns queued step results into result requests
// depends on dox_pkg
module dox_back import dox_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  act_t q_data,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic pend_r, pend_nxt;
  out_t pend_data_r, pend_data_nxt;
  logic load;
  out_t byte_res;
  out_t stat_res;

  assign load = !out_valid_r || out_ready;

  always_comb begin
    byte_res.result_kind = RK_BYTE;
    byte_res.copied_byte = q_data.copied_byte;
    byte_res.found       = 1'b0;
    byte_res.byte_count  = 8'd0;
    byte_res.run_last    = 1'b0;
    stat_res.result_kind = RK_STATUS;
    stat_res.copied_byte = 8'd0;
    stat_res.found       = q_data.found;
    stat_res.byte_count  = q_data.byte_count;
    stat_res.run_last    = 1'b1;
  end

  always_comb begin
    pop           = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pend_nxt      = pend_r;
    pend_data_nxt = pend_data_r;
    if (load) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = pend_data_r;
        pend_nxt      = 1'b0;
      end else if (q_valid) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        if (q_data.has_byte) begin
          out_data_nxt  = byte_res;
          pend_nxt      = q_data.has_status;
          pend_data_nxt = stat_res;
        end else begin
          out_data_nxt = stat_res;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    pend_data_r <= pend_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pend_behind_byte: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (out_valid_r && out_data_r.result_kind == RK_BYTE))
    else $error("held status without a byte in front of it");

  a_no_pop_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !pop)
    else $error("queue popped while a status was still held");

endmodule

### sv/dhcp_option_extractor_top.sv
// top level of the dhcp option extractor: config registers, front, queue, back
// depends on dox_pkg, dox_front, dox_queue, dox_back
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_ready   in_t  {option_byte, area_last}
//  out_     output     out_valid/out_ready out_t {result_kind .. run_last}
//  cfg      apb        psel/penable/pready wanted_type, copy_length, exact_mode
//
// one option byte is accepted per cycle while the queue has room
// results leave the output register one per cycle while out_ready is high
// a byte that closes the area inside the copied body yields two results, byte
// then status; the queue absorbs this and stalls the input only when full
// synchronous active-low reset clears the walk, queue and output; config resets
// to wanted_type 53, copy_length 1, exact_mode 1
module dhcp_option_extractor_top import dox_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_valid;
  act_t       q_wdata;
  act_t       q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wanted_type <= WANTED_TYPE_RST;
      cfg_r.copy_length <= COPY_LENGTH_RST;
      cfg_r.exact_mode  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WANTED_TYPE: cfg_r.wanted_type <= pwdata[7:0];
        REG_COPY_LENGTH: cfg_r.copy_length <= pwdata[7:0];
        REG_EXACT_MODE:  cfg_r.exact_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WANTED_TYPE: prdata = {24'd0, cfg_r.wanted_type};
      REG_COPY_LENGTH: prdata = {24'd0, cfg_r.copy_length};
      REG_EXACT_MODE:  prdata = {31'd0, cfg_r.exact_mode};
      default:         prdata = 32'd0;
    endcase
  end

  dox_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  dox_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_rdata)
  );

  dox_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
